// ----- rtl/rbit_pkg.sv -----
// ----------------------------------------------------------------------------
// rbit_pkg
// Shared codes for the ray versus box hit test: box kinds and register indexes.
// ----------------------------------------------------------------------------
package rbit_pkg;

  localparam int unsigned KindW = 2;
  localparam int unsigned RegIdxW = 3;

  localparam logic [KindW-1:0] KIND_FINITE   = 2'd0;
  localparam logic [KindW-1:0] KIND_EMPTY    = 2'd1;
  localparam logic [KindW-1:0] KIND_INFINITE = 2'd2;

  localparam logic [RegIdxW-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [RegIdxW-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [RegIdxW-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [RegIdxW-1:0] REG_DIR_X    = 3'd3;
  localparam logic [RegIdxW-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [RegIdxW-1:0] REG_DIR_Z    = 3'd5;

endpackage

// ----- rtl/rbit_if.sv -----
// ----------------------------------------------------------------------------
// rbit_box_if / rbit_hit_if
// Valid/ready channels for box items and hit results.
// ----------------------------------------------------------------------------
interface rbit_box_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] box_min_x;
  logic signed [COORD_WIDTH-1:0] box_min_y;
  logic signed [COORD_WIDTH-1:0] box_min_z;
  logic signed [COORD_WIDTH-1:0] box_max_x;
  logic signed [COORD_WIDTH-1:0] box_max_y;
  logic signed [COORD_WIDTH-1:0] box_max_z;
  logic [rbit_pkg::KindW-1:0]    box_kind;

  modport source (
    output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           box_kind,
    input  ready
  );
  modport sink (
    input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           box_kind,
    output ready
  );
endinterface

interface rbit_hit_if;
  logic valid;
  logic ready;
  logic hits;

  modport source (output valid, hits, input ready);
  modport sink (input valid, hits, output ready);
endinterface

// ----- rtl/ray_box_intersect_test_unit.sv -----
// ----------------------------------------------------------------------------
// ray_box_intersect_test_unit
// Throughput: one box per cycle while res.ready does not hold back a full pipeline;
// the restoring divider retires one quotient bit per stage over its
// COORD_WIDTH + FRAC_BITS stages.
// Reset: asynchronous, active low; clears ray registers to zero and empties
// the pipeline.
// ----------------------------------------------------------------------------
module ray_box_intersect_test_unit #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rbit_pkg::RegIdxW-1:0]      cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]            cfg_wdata_i,
  rbit_box_if.sink                          box,
  rbit_hit_if.source                        res
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned QW = COORD_WIDTH + FRAC_BITS;
  localparam int unsigned DS = QW;
  localparam int unsigned NS = DS + 4;
  localparam int unsigned SelS = DS + 1;
  localparam int unsigned MulS = DS + 2;
  localparam int unsigned OutS = DS + 3;
  localparam int unsigned TW = CW - 1;
  localparam int unsigned PW = TW + CW;
  localparam int unsigned FW = 2 * CW + 2;
  localparam logic [TW-1:0] TMax = {TW{1'b1}};

  typedef struct packed {
    logic                   dec;
    logic                   dval;
    logic [2:0]             cand;
    logic [2:0][CW-1:0]     n;
    logic [2:0][CW-1:0]     r;
    logic [2:0][QW-1:0]     q;
    logic [2:0][CW-1:0]     bmin;
    logic [2:0][CW-1:0]     bmax;
  } div_t;

  typedef struct packed {
    logic                   dec;
    logic                   dval;
    logic [1:0]             best;
    logic [TW-1:0]          tb;
    logic [2:0][CW-1:0]     bmin;
    logic [2:0][CW-1:0]     bmax;
  } sel_t;

  typedef struct packed {
    logic                   dec;
    logic                   dval;
    logic [1:0]             best;
    logic [2:0][PW-1:0]     prod;
    logic [2:0][CW-1:0]     bmin;
    logic [2:0][CW-1:0]     bmax;
  } mul_t;

  logic [2:0][CW-1:0] org_q;
  logic [2:0][CW-1:0] dir_q;
  logic [2:0][CW-1:0] dmag;
  logic [NS-1:0]      v_q;
  logic [NS-1:0]      en;
  div_t               p_q [DS+1];
  div_t               p_d [DS+1];
  sel_t               sel_q, sel_d;
  mul_t               mul_q, mul_d;
  logic               hit_q, hit_d;

  // ray registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q <= '0;
      dir_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rbit_pkg::REG_ORIGIN_X: org_q[0] <= cfg_wdata_i;
        rbit_pkg::REG_ORIGIN_Y: org_q[1] <= cfg_wdata_i;
        rbit_pkg::REG_ORIGIN_Z: org_q[2] <= cfg_wdata_i;
        rbit_pkg::REG_DIR_X:    dir_q[0] <= cfg_wdata_i;
        rbit_pkg::REG_DIR_Y:    dir_q[1] <= cfg_wdata_i;
        rbit_pkg::REG_DIR_Z:    dir_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dmag[a] = dir_q[a][CW-1] ? (~dir_q[a] + 1'b1) : dir_q[a];
    end
  end

  // stall chain
  always_comb begin
    en[NS-1] = !v_q[NS-1] || res.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign box.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= box.valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // decode stage: slab tests and entry numerators
  always_comb begin
    logic [2:0][CW-1:0] bmn;
    logic [2:0][CW-1:0] bmx;
    logic lt, gt, org_in, dpos;
    bmn = {box.box_min_z, box.box_min_y, box.box_min_x};
    bmx = {box.box_max_z, box.box_max_y, box.box_max_x};
    org_in = 1'b1;
    p_d[0] = '0;
    p_d[0].bmin = bmn;
    p_d[0].bmax = bmx;
    for (int a = 0; a < 3; a++) begin
      lt = $signed(org_q[a]) < $signed(bmn[a]);
      gt = !lt && ($signed(bmx[a]) < $signed(org_q[a]));
      dpos = !dir_q[a][CW-1] && (|dir_q[a]);
      if (lt || gt) org_in = 1'b0;
      p_d[0].cand[a] = (lt && dpos) || (gt && dir_q[a][CW-1]);
      p_d[0].n[a] = lt ? (bmn[a] - org_q[a]) : (org_q[a] - bmx[a]);
    end
    case (box.box_kind)
      rbit_pkg::KIND_FINITE: begin
        p_d[0].dec  = org_in || !(|p_d[0].cand);
        p_d[0].dval = org_in;
      end
      rbit_pkg::KIND_INFINITE: begin
        p_d[0].dec  = 1'b1;
        p_d[0].dval = 1'b1;
      end
      default: begin
        p_d[0].dec  = 1'b1;
        p_d[0].dval = 1'b0;
      end
    endcase
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 1; k <= DS; k++) begin : g_div
    always_comb begin
      logic [CW:0] trial;
      logic        ge;
      p_d[k] = p_q[k-1];
      for (int a = 0; a < 3; a++) begin
        trial = {p_q[k-1].r[a], p_q[k-1].n[a][CW-1]};
        ge = trial >= {1'b0, dmag[a]};
        p_d[k].r[a] = ge ? CW'(trial - {1'b0, dmag[a]}) : CW'(trial);
        p_d[k].n[a] = p_q[k-1].n[a] << 1;
        p_d[k].q[a] = {p_q[k-1].q[a][QW-2:0], ge};
      end
    end
  end

  for (genvar k = 0; k <= DS; k++) begin : g_pay
    always_ff @(posedge clk_i) begin
      if (en[k]) p_q[k] <= p_d[k];
    end
  end

  // entry plane select, ties to the lower axis
  always_comb begin
    logic [2:0][TW-1:0] t;
    logic               have;
    for (int a = 0; a < 3; a++) begin
      t[a] = (|p_q[DS].q[a][QW-1:TW]) ? TMax : p_q[DS].q[a][TW-1:0];
    end
    have = p_q[DS].cand[0];
    sel_d.best = 2'd0;
    sel_d.tb = t[0];
    for (int a = 1; a < 3; a++) begin
      if (p_q[DS].cand[a] && (!have || t[a] > sel_d.tb)) begin
        sel_d.best = 2'(a);
        sel_d.tb = t[a];
        have = 1'b1;
      end
    end
    sel_d.dec  = p_q[DS].dec;
    sel_d.dval = p_q[DS].dval;
    sel_d.bmin = p_q[DS].bmin;
    sel_d.bmax = p_q[DS].bmax;
  end

  always_comb begin
    mul_d.dec  = sel_q.dec;
    mul_d.dval = sel_q.dval;
    mul_d.best = sel_q.best;
    mul_d.bmin = sel_q.bmin;
    mul_d.bmax = sel_q.bmax;
    for (int a = 0; a < 3; a++) begin
      mul_d.prod[a] = PW'(sel_q.tb) * PW'(dmag[a]);
    end
  end

  // cross coordinates against the widened box
  always_comb begin
    logic [FW-1:0] sh, f, lo, hi;
    logic          ok;
    ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      sh = {{(FW-PW){1'b0}}, mul_q.prod[a] >> FRAC_BITS};
      f  = {{(FW-CW){org_q[a][CW-1]}}, org_q[a]} + (dir_q[a][CW-1] ? (~sh + 1'b1) : sh);
      lo = {{(FW-CW){mul_q.bmin[a][CW-1]}}, mul_q.bmin[a]} - 1'b1;
      hi = {{(FW-CW){mul_q.bmax[a][CW-1]}}, mul_q.bmax[a]} + 1'b1;
      if (mul_q.best != 2'(a) && ($signed(f) < $signed(lo) || $signed(hi) < $signed(f))) begin
        ok = 1'b0;
      end
    end
    hit_d = mul_q.dec ? mul_q.dval : ok;
  end

  always_ff @(posedge clk_i) begin
    if (en[SelS]) sel_q <= sel_d;
    if (en[MulS]) mul_q <= mul_d;
    if (en[OutS]) hit_q <= hit_d;
  end

  assign res.valid = v_q[OutS];
  assign res.hits  = hit_q;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !box.ready |-> (v_q[OutS] && !res.ready))
    else $error("input stalled while output stage can drain");

  a_best_axis_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[MulS] && !mul_q.dec) |-> (mul_q.best != 2'd3))
    else $error("entry plane select out of range");

  a_out_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[MulS] && en[OutS]) |=> v_q[OutS])
    else $error("result lost between multiply and output stage");
`endif

endmodule
